// ===== hdl/ffrp_pkg.sv =====
// ----------------------------------------------------------------------------
// ffrp_pkg
// Shared sizes, codes and controller/datapath bundles of the rectangle packer.
// ----------------------------------------------------------------------------
package ffrp_pkg;

  // Largest atlas side in cells; the occupancy map is MAX_DIM x MAX_DIM.
  localparam int MAX_DIM = 64;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int FLD_W   = 7;
  localparam int POS_W   = 6;
  localparam int CMP_W   = ((DIM_W > FLD_W) ? DIM_W : FLD_W) + 1;

  localparam logic [FLD_W-1:0] ATLAS_RESET = 7'd64;

  localparam logic REG_ATLAS_W = 1'b0;
  localparam logic REG_ATLAS_H = 1'b1;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic accept;     // latch a new request
    logic clear_map;  // drop every row of the map
    logic set_rot;    // switch to the swapped orientation
    logic y_clr;      // restart the scan at the top row
    logic y_inc;      // next candidate row
    logic row_init;   // clear the row union and counters
    logic acc_issue;  // read one row of the rectangle band
    logic x_inc;      // next candidate column
    logic mark_init;  // start marking the found area
    logic mark_rd;    // read a row to be marked
    logic mark_wr;    // write the marked row back
    logic out_load;   // load the result register
    logic out_placed; // placed flag of the result
  } ffrp_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic fits;
    logic acc_last;
    logic win_free;
    logic x_last;
    logic y_last;
    logic rot;
    logic out_free;
  } ffrp_sts_t;

  // Saturates an atlas size to the map side.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [FLD_W-1:0] v);
    logic [CMP_W-1:0] e;
    e = CMP_W'(v);
    if (e > CMP_W'(MAX_DIM)) begin
      e = CMP_W'(MAX_DIM);
    end
    return e[DIM_W-1:0];
  endfunction

  // Positions are reported modulo 64.
  function automatic logic [POS_W-1:0] to_pos(input logic [DIM_W-1:0] v);
    logic [DIM_W+POS_W-1:0] t;
    t = {{POS_W{1'b0}}, v};
    return t[POS_W-1:0];
  endfunction

endpackage

// ===== hdl/ffrp_ram.sv =====
// ----------------------------------------------------------------------------
// ffrp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ffrp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ffrp_dp.sv =====
// ----------------------------------------------------------------------------
// ffrp_dp
// Datapath: atlas registers, occupancy map, scan counters and result register.
// ----------------------------------------------------------------------------
module ffrp_dp import ffrp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [FLD_W-1:0] cfg_wdata_i,
  input  logic             op_i,
  input  logic [FLD_W-1:0] rect_w_i,
  input  logic [FLD_W-1:0] rect_h_i,
  input  ffrp_cmd_t        cmd_i,
  output ffrp_sts_t        sts_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic             placed_o,
  output logic             rotated_o,
  output logic [POS_W-1:0] pos_x_o,
  output logic [POS_W-1:0] pos_y_o
);

  logic [FLD_W-1:0]   atlas_w_q, atlas_h_q;
  logic               op_q, rot_q;
  logic [FLD_W-1:0]   req_w_q, req_h_q;
  logic [DIM_W-1:0]   x_q, y_q, r_q;
  logic [MAX_DIM-1:0] union_q;
  logic [MAX_DIM-1:0] row_vld_q;
  logic               vld_rd_q, acc_v_q;
  logic               out_valid_q, placed_q, rotated_q;
  logic [POS_W-1:0]   pos_x_q, pos_y_q;

  logic [DIM_W-1:0]   atlas_wc, atlas_hc, cw, ch, row_sum;
  logic [FLD_W-1:0]   sel_w, sel_h;
  logic [IDX_W-1:0]   row_addr;
  logic [MAX_DIM-1:0] rdata, rd_row, low_mask, win;
  logic               out_free;

  assign atlas_wc = clamp_dim(atlas_w_q);
  assign atlas_hc = clamp_dim(atlas_h_q);
  assign sel_w    = rot_q ? req_h_q : req_w_q;
  assign sel_h    = rot_q ? req_w_q : req_h_q;
  assign cw       = DIM_W'(sel_w);
  assign ch       = DIM_W'(sel_h);

  assign row_sum  = y_q + r_q;
  assign row_addr = row_sum[IDX_W-1:0];
  // A row that was never written since the last clear reads as all free.
  assign rd_row   = vld_rd_q ? rdata : '0;
  assign low_mask = {MAX_DIM{1'b1}} >> (DIM_W'(MAX_DIM) - cw);
  assign win      = (union_q >> x_q) & low_mask;
  assign out_free = !out_valid_q || !out_stall_i;

  ffrp_ram #(
    .Width(MAX_DIM),
    .Depth(MAX_DIM)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (cmd_i.mark_wr),
    .waddr_i(row_addr),
    .wdata_i(rd_row | (low_mask << x_q)),
    .re_i   (cmd_i.acc_issue || cmd_i.mark_rd),
    .raddr_i(row_addr),
    .rdata_o(rdata)
  );

  always_comb begin
    sts_o.op_clear = (op_q == OP_CLEAR);
    sts_o.fits     = (sel_w != '0) && (sel_h != '0)
                     && (CMP_W'(sel_w) <= CMP_W'(atlas_wc))
                     && (CMP_W'(sel_h) <= CMP_W'(atlas_hc));
    sts_o.acc_last = (r_q == ch - DIM_W'(1));
    sts_o.win_free = (win == '0);
    sts_o.x_last   = (x_q == atlas_wc - cw);
    sts_o.y_last   = (y_q == atlas_hc - ch);
    sts_o.rot      = rot_q;
    sts_o.out_free = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q   <= ATLAS_RESET;
      atlas_h_q   <= ATLAS_RESET;
      row_vld_q   <= '0;
      acc_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ATLAS_W: atlas_w_q <= cfg_wdata_i;
          REG_ATLAS_H: atlas_h_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.clear_map) begin
        row_vld_q <= '0;
      end else if (cmd_i.mark_wr) begin
        row_vld_q[row_addr] <= 1'b1;
      end
      acc_v_q <= cmd_i.acc_issue;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= op_i;
      req_w_q <= rect_w_i;
      req_h_q <= rect_h_i;
      rot_q   <= 1'b0;
    end else if (cmd_i.set_rot) begin
      rot_q   <= 1'b1;
    end
    if (cmd_i.acc_issue || cmd_i.mark_rd) begin
      vld_rd_q <= row_vld_q[row_addr];
    end
    if (cmd_i.y_clr) begin
      y_q <= '0;
    end else if (cmd_i.y_inc) begin
      y_q <= y_q + DIM_W'(1);
    end
    if (cmd_i.row_init) begin
      x_q <= '0;
    end else if (cmd_i.x_inc) begin
      x_q <= x_q + DIM_W'(1);
    end
    if (cmd_i.row_init || cmd_i.mark_init) begin
      r_q <= '0;
    end else if (cmd_i.acc_issue || cmd_i.mark_wr) begin
      r_q <= r_q + DIM_W'(1);
    end
    // Read data is registered and lands in the cycle after the read, so the union trails the reads.
    if (cmd_i.row_init) begin
      union_q <= '0;
    end else if (acc_v_q) begin
      union_q <= union_q | rd_row;
    end
    if (cmd_i.out_load) begin
      placed_q  <= cmd_i.out_placed;
      rotated_q <= cmd_i.out_placed && rot_q;
      pos_x_q   <= cmd_i.out_placed ? to_pos(x_q) : '0;
      pos_y_q   <= cmd_i.out_placed ? to_pos(y_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign placed_o    = placed_q;
  assign rotated_o   = rotated_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;

endmodule

// ===== hdl/ffrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffrp_ctrl
// Controller: sequences the band reads, window tests, marking and result.
// ----------------------------------------------------------------------------
module ffrp_ctrl import ffrp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ffrp_sts_t sts_i,
  output ffrp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SETUP,
    ST_ROW,
    ST_ACC,
    ST_ACC_WAIT,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   hit_q, hit_d;

  always_comb begin
    state_d = state_q;
    hit_d   = hit_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.op_clear) begin
          cmd_o.clear_map = 1'b1;
          hit_d           = 1'b0;
          state_d         = ST_RESULT;
        end else begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (sts_i.fits) begin
          cmd_o.y_clr = 1'b1;
          state_d     = ST_ROW;
        end else if (!sts_i.rot) begin
          cmd_o.set_rot = 1'b1;
        end else begin
          hit_d   = 1'b0;
          state_d = ST_RESULT;
        end
      end
      ST_ROW: begin
        cmd_o.row_init = 1'b1;
        state_d        = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_issue = 1'b1;
        if (sts_i.acc_last) begin
          state_d = ST_ACC_WAIT;
        end
      end
      ST_ACC_WAIT: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.win_free) begin
          cmd_o.mark_init = 1'b1;
          state_d         = ST_MARK_RD;
        end else if (!sts_i.x_last) begin
          cmd_o.x_inc = 1'b1;
        end else if (!sts_i.y_last) begin
          cmd_o.y_inc = 1'b1;
          state_d     = ST_ROW;
        end else if (!sts_i.rot) begin
          cmd_o.set_rot = 1'b1;
          state_d       = ST_SETUP;
        end else begin
          hit_d   = 1'b0;
          state_d = ST_RESULT;
        end
      end
      ST_MARK_RD: begin
        cmd_o.mark_rd = 1'b1;
        state_d       = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        cmd_o.mark_wr = 1'b1;
        if (sts_i.acc_last) begin
          hit_d   = 1'b1;
          state_d = ST_RESULT;
        end else begin
          state_d = ST_MARK_RD;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_placed = hit_q;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hit_q   <= hit_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ===== hdl/first_fit_rect_packer_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_rect_packer_unit
// First-fit rectangle packer over a row-organized occupancy bitmap.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i/in_stall_o    op_i, rect_w_i, rect_h_i
//  out      output     out_valid_o/out_stall_i  placed_o, rotated_o, pos_x_o, pos_y_o
//  cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One request is in work at a time. A clear drops the per-row valid flags
// and goes straight to the result. A placement reads and merges each
// candidate band of h map rows through the single RAM read port, tests the
// columns one at a time and marks the found area, reading and writing each row.
// Reset clears the per-row valid flags at once, so no clearing pass is needed.
// A stalled result stays in the output register while the next request runs.
// ----------------------------------------------------------------------------
module first_fit_rect_packer_unit import ffrp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [FLD_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             op_i,
  input  logic [FLD_W-1:0] rect_w_i,
  input  logic [FLD_W-1:0] rect_h_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             placed_o,
  output logic             rotated_o,
  output logic [POS_W-1:0] pos_x_o,
  output logic [POS_W-1:0] pos_y_o
);

  ffrp_cmd_t cmd;
  ffrp_sts_t sts;

  ffrp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ffrp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .op_i       (op_i),
    .rect_w_i   (rect_w_i),
    .rect_h_i   (rect_h_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .placed_o   (placed_o),
    .rotated_o  (rotated_o),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o)
  );

endmodule

// ===== bench/tb_first_fit_rect_packer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_rect_packer_unit
// Self-checking bench for the first-fit rectangle packer. A tracker class
// keeps its own occupancy map and atlas size, works out the placement every
// accepted request should get, and compares each result transfer against the
// oldest placement due. Directed requests cover the edge cases, then random
// phases sweep atlas sizes and idle/stall mixes on both channels.
// ----------------------------------------------------------------------------
module tb_first_fit_rect_packer_unit;
  import ffrp_pkg::*;

  typedef struct packed {
    logic             placed;
    logic             rotated;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } placement_t;

  class atlas_tracker;
    bit [MAX_DIM-1:0] occ[MAX_DIM];
    bit [FLD_W-1:0]   atlas_w;
    bit [FLD_W-1:0]   atlas_h;
    placement_t       placements_due[$];
    int               errors;

    function new();
      foreach (occ[r]) occ[r] = '0;
      atlas_w = ATLAS_RESET;
      atlas_h = ATLAS_RESET;
      errors  = 0;
    endfunction

    function void set_reg(logic idx, logic [FLD_W-1:0] val);
      if (idx == REG_ATLAS_W) begin
        atlas_w = val;
      end else begin
        atlas_h = val;
      end
    endfunction

    // First free top-left position in raster order; marks the area on a hit.
    function bit fit_scan(int w, int h, int aw, int ah, output int px, output int py);
      bit [MAX_DIM:0]   wide;
      bit [MAX_DIM-1:0] mask;
      bit               clash;
      px = 0;
      py = 0;
      if (w == 0 || h == 0 || w > aw || h > ah) return 1'b0;
      wide = ({{MAX_DIM{1'b0}}, 1'b1} << w) - 1;
      mask = wide[MAX_DIM-1:0];
      for (int y = 0; y + h <= ah; y++) begin
        for (int x = 0; x + w <= aw; x++) begin
          if (occ[y][x]) continue;
          clash = 1'b0;
          for (int r = y; r < y + h; r++) begin
            if (((occ[r] >> x) & mask) != '0) clash = 1'b1;
          end
          if (!clash) begin
            for (int r = y; r < y + h; r++) occ[r] |= mask << x;
            px = x;
            py = y;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic op, logic [FLD_W-1:0] w, logic [FLD_W-1:0] h);
      placement_t want;
      int         aw;
      int         ah;
      int         px;
      int         py;
      aw = (atlas_w > MAX_DIM) ? MAX_DIM : atlas_w;
      ah = (atlas_h > MAX_DIM) ? MAX_DIM : atlas_h;
      want = '0;
      if (op == OP_CLEAR) begin
        foreach (occ[r]) occ[r] = '0;
      end else if (fit_scan(w, h, aw, ah, px, py)) begin
        want.placed = 1'b1;
        want.pos_x  = px[POS_W-1:0];
        want.pos_y  = py[POS_W-1:0];
      end else if (fit_scan(h, w, aw, ah, px, py)) begin
        want.placed  = 1'b1;
        want.rotated = 1'b1;
        want.pos_x   = px[POS_W-1:0];
        want.pos_y   = py[POS_W-1:0];
      end
      placements_due.insert(placements_due.size(), want);
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_result(logic placed, logic rotated,
                               logic [POS_W-1:0] px, logic [POS_W-1:0] py);
      placement_t want;
      if (placements_due.size() == 0) begin
        flag("unrequested result (placed)", -1, placed);
        return;
      end
      want = placements_due.pop_front();
      if (placed !== want.placed) flag("placed", want.placed, placed);
      if (rotated !== want.rotated) flag("rotated", want.rotated, rotated);
      if (px !== want.pos_x) flag("pos_x", want.pos_x, px);
      if (py !== want.pos_y) flag("pos_y", want.pos_y, py);
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = REG_ATLAS_W;
  logic [FLD_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             op_i = OP_PLACE;
  logic [FLD_W-1:0] rect_w_i = '0;
  logic [FLD_W-1:0] rect_h_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             placed_o;
  logic             rotated_o;
  logic [POS_W-1:0] pos_x_o;
  logic [POS_W-1:0] pos_y_o;

  atlas_tracker board;
  int           send_idle_pct = 0;
  int           stall_pct = 0;

  first_fit_rect_packer_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .rect_w_i   (rect_w_i),
    .rect_h_i   (rect_h_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .placed_o   (placed_o),
    .rotated_o  (rotated_o),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(placed_o, rotated_o, pos_x_o, pos_y_o);
    end
  end

  task automatic send_request(input logic op, input logic [FLD_W-1:0] w,
                              input logic [FLD_W-1:0] h);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    rect_w_i   <= w;
    rect_h_i   <= h;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(op, w, h);
  endtask

  task automatic write_reg(input logic idx, input logic [FLD_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Holds the request channel off until every placement due has come back.
  task automatic drain_results;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.placements_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly sides that fit the atlas; now and then anything the field holds.
  function automatic logic [FLD_W-1:0] pick_side(int span);
    if ($urandom_range(9) == 0) return FLD_W'($urandom_range(127));
    return FLD_W'($urandom_range(span, 1));
  endfunction

  initial begin
    int aw;
    int ah;
    int span;
    board = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default 64 x 64 atlas.
    send_request(OP_PLACE, 7'd64, 7'd64);
    send_request(OP_PLACE, 7'd1, 7'd1);
    send_request(OP_CLEAR, 7'd0, 7'd0);
    send_request(OP_PLACE, 7'd0, 7'd5);
    send_request(OP_PLACE, 7'd5, 7'd0);
    send_request(OP_PLACE, 7'd127, 7'd3);
    send_request(OP_PLACE, 7'd64, 7'd1);
    send_request(OP_PLACE, 7'd1, 7'd64);
    send_request(OP_PLACE, 7'd3, 7'd5);
    send_request(OP_PLACE, 7'd1, 7'd1);
    send_request(OP_CLEAR, 7'd127, 7'd127);
    drain_results();

    // A narrow strip: a tall request only fits on its side.
    write_reg(REG_ATLAS_W, 7'd10);
    write_reg(REG_ATLAS_H, 7'd4);
    send_request(OP_PLACE, 7'd4, 7'd10);
    send_request(OP_CLEAR, 7'd0, 7'd0);
    repeat (3) send_request(OP_PLACE, 7'd3, 7'd3);
    send_request(OP_PLACE, 7'd2, 7'd2);
    send_request(OP_PLACE, 7'd1, 7'd4);
    drain_results();

    // Zero width admits nothing; then an oversized width saturates while
    // the cells taken above stay where they were.
    write_reg(REG_ATLAS_W, 7'd0);
    send_request(OP_PLACE, 7'd1, 7'd1);
    drain_results();
    write_reg(REG_ATLAS_W, 7'd127);
    write_reg(REG_ATLAS_H, 7'd1);
    send_request(OP_PLACE, 7'd64, 7'd1);
    send_request(OP_PLACE, 7'd20, 7'd1);
    send_request(OP_CLEAR, 7'd0, 7'd0);

    for (int p = 0; p < 8; p++) begin
      drain_results();
      case (p)
        0: begin aw = 64; ah = 64; end
        1: begin aw = 1; ah = 1; end
        2: begin aw = $urandom_range(24, 1); ah = $urandom_range(24, 1); end
        3: begin aw = 127; ah = 100; end
        4: begin aw = $urandom_range(64, 1); ah = $urandom_range(64, 1); end
        5: begin aw = 0; ah = $urandom_range(64, 1); end
        6: begin aw = $urandom_range(12, 1); ah = $urandom_range(12, 1); end
        default: begin aw = 64; ah = $urandom_range(64, 1); end
      endcase
      write_reg(REG_ATLAS_W, FLD_W'(aw));
      write_reg(REG_ATLAS_H, FLD_W'(ah));
      case (p % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 45; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 45; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      if (aw > MAX_DIM) aw = MAX_DIM;
      if (ah > MAX_DIM) ah = MAX_DIM;
      span = ((aw < ah) ? aw : ah) / 3;
      if (span < 1) span = 1;
      repeat (15) begin
        if ($urandom_range(19) == 0) drain_results();
        if ($urandom_range(11) == 0) begin
          send_request(OP_CLEAR, FLD_W'($urandom_range(127)), FLD_W'($urandom_range(127)));
        end else begin
          send_request(OP_PLACE, pick_side(span), pick_side(span));
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
